/* hw/rtl/tnd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnd_pkg
// Shared types and codes for the tick to nanosecond and deadline unit.
// ----------------------------------------------------------------------------
package tnd_pkg;

    // fixed point fraction bits of both multipliers
    localparam int unsigned FRAC_BITS = 32;

    // request kinds
    localparam logic [1:0] KIND_MONO     = 2'd0;
    localparam logic [1:0] KIND_REAL     = 2'd1;
    localparam logic [1:0] KIND_DEADLINE = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NOT_INIT = 2'd1;
    localparam logic [1:0] STATUS_PASSED   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_NS_PER_TICK = 2'd0;
    localparam logic [1:0] REG_TICKS_PER_NS = 2'd1;
    localparam logic [1:0] REG_BOOT_OFFSET = 2'd2;
    localparam logic [1:0] REG_TIME_VALID  = 2'd3;

    // request beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] ticks_now;
        logic [63:0] target_ns;
    } tnd_req_t;

    // result beat
    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } tnd_res_t;

endpackage
`default_nettype wire

/* hw/rtl/tick_to_ns_deadline_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tick_to_ns_deadline_unit
// Converts sampled timebase ticks to monotonic or realtime nanoseconds and
// turns a target time into a deadline in ticks.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (kind, ticks_now, target_ns) is taken at a clock edge
//   with start high; busy stays low, so a request may enter every cycle.
//   Each request gives exactly one result beat, shown on result for one
//   cycle with done high. Results leave in request order; the receiver
//   cannot hold them off and the pipeline never stalls.
//   Throughput is one request per cycle. A request passes an input register,
//   two chained two stage 64x64 multipliers (ticks to ns, then ns delta to
//   ticks) with a compare stage between them, and an output register.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data):
//   0 ns per tick multiplier, 1 ticks per ns multiplier, 2 boot offset,
//   3 time valid flag (bit 0). Writes land at once; write only when idle.
//   Reset clears configuration and valid bits; requests in flight are dropped.
// ----------------------------------------------------------------------------
module tick_to_ns_deadline_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire tnd_pkg::tnd_req_t req,
    output logic                  done,
    output tnd_pkg::tnd_res_t     result,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [63:0]      cfg_data
);
    import tnd_pkg::*;

    // configuration registers
    logic [63:0] ns_mult_reg, tick_mult_reg, boot_reg;
    logic        time_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_mult_reg    <= '0;
            tick_mult_reg  <= '0;
            boot_reg       <= '0;
            time_valid_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NS_PER_TICK:  ns_mult_reg    <= cfg_data;
                REG_TICKS_PER_NS: tick_mult_reg  <= cfg_data;
                REG_BOOT_OFFSET:  boot_reg       <= cfg_data;
                REG_TIME_VALID:   time_valid_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // valid bits, one per stage
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, done_reg;
    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= accept;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    // input register and side band through the first multiplier
    tnd_req_t    s0_reg;
    logic [1:0]  p1_kind_reg, p2_kind_reg;
    logic [63:0] p1_ticks_reg, p2_ticks_reg, p1_target_reg, p2_target_reg;

    always_ff @(posedge clk)
    begin
        s0_reg        <= req;
        p1_kind_reg   <= s0_reg.kind;
        p1_ticks_reg  <= s0_reg.ticks_now;
        p1_target_reg <= s0_reg.target_ns;
        p2_kind_reg   <= p1_kind_reg;
        p2_ticks_reg  <= p1_ticks_reg;
        p2_target_reg <= p1_target_reg;
    end

    // ticks to monotonic ns
    logic [63:0] now_ns;

    tnd_mul_shift u_now_mul (
        .clk     (clk),
        .a       (s0_reg.ticks_now),
        .b       (ns_mult_reg),
        .product (now_ns)
    );

    // decide kind and status, form the ns delta
    logic [63:0] delta;
    logic [63:0] early_next;
    logic [1:0]  status_next;
    logic        need_next;

    assign delta = p2_target_reg - now_ns;

    always_comb
    begin
        early_next  = '0;
        status_next = STATUS_OK;
        need_next   = 1'b0;
        case (p2_kind_reg)
            KIND_MONO:
            begin
                early_next = now_ns;
            end
            KIND_REAL:
            begin
                early_next = boot_reg + now_ns;
            end
            KIND_DEADLINE:
            begin
                if (!time_valid_reg)
                    status_next = STATUS_NOT_INIT;
                else if ((delta == '0) || delta[63])
                    status_next = STATUS_PASSED;
                else
                    need_next = 1'b1;
            end
            default:
            begin
                early_next = '0;
            end
        endcase
    end

    logic [63:0] s3_delta_reg, s3_early_reg, s3_ticks_reg;
    logic [1:0]  s3_status_reg;
    logic        s3_need_reg;
    logic [63:0] p4_early_reg, p5_early_reg, p4_ticks_reg, p5_ticks_reg;
    logic [1:0]  p4_status_reg, p5_status_reg;
    logic        p4_need_reg, p5_need_reg;

    always_ff @(posedge clk)
    begin
        s3_delta_reg  <= delta;
        s3_early_reg  <= early_next;
        s3_ticks_reg  <= p2_ticks_reg;
        s3_status_reg <= status_next;
        s3_need_reg   <= need_next;
        p4_early_reg  <= s3_early_reg;
        p4_ticks_reg  <= s3_ticks_reg;
        p4_status_reg <= s3_status_reg;
        p4_need_reg   <= s3_need_reg;
        p5_early_reg  <= p4_early_reg;
        p5_ticks_reg  <= p4_ticks_reg;
        p5_status_reg <= p4_status_reg;
        p5_need_reg   <= p4_need_reg;
    end

    // ns delta to ticks
    logic [63:0] delta_ticks;

    tnd_mul_shift u_tick_mul (
        .clk     (clk),
        .a       (s3_delta_reg),
        .b       (tick_mult_reg),
        .product (delta_ticks)
    );

    // output register
    tnd_res_t res_reg;
    tnd_res_t res_next;

    always_comb
    begin
        res_next.status = p5_status_reg;
        res_next.value  = p5_need_reg ? (p5_ticks_reg + delta_ticks) : p5_early_reg;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

/* hw/rtl/tnd_mul_shift.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnd_mul_shift
// Two stage 64x64 fixed point multiply keeping bits 32..95 of the product.
// Stage one forms four 32x32 partial products, stage two sums them.
// ----------------------------------------------------------------------------
module tnd_mul_shift (
    input  wire logic        clk,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic      [63:0] product
);
    import tnd_pkg::*;

    logic [63:0] hh_reg, hl_reg, lh_reg, ll_reg;
    logic [63:0] hh_next, hl_next, lh_next, ll_next;
    logic [63:0] product_reg;
    logic [63:0] product_next;

    // partial products
    always_comb
    begin
        hh_next = a[63:FRAC_BITS] * b[63:FRAC_BITS];
        hl_next = a[63:FRAC_BITS] * b[FRAC_BITS-1:0];
        lh_next = a[FRAC_BITS-1:0] * b[63:FRAC_BITS];
        ll_next = a[FRAC_BITS-1:0] * b[FRAC_BITS-1:0];
    end

    // aligned sum, wraps modulo 2^64
    always_comb
    begin
        product_next = {hh_reg[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}
                     + hl_reg + lh_reg
                     + {{FRAC_BITS{1'b0}}, ll_reg[63:FRAC_BITS]};
    end

    always_ff @(posedge clk)
    begin
        hh_reg      <= hh_next;
        hl_reg      <= hl_next;
        lh_reg      <= lh_next;
        ll_reg      <= ll_next;
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule
`default_nettype wire

/* hw/rtl/tnd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnd_checker
// Port level checks for the tick to nanosecond and deadline unit.
// ----------------------------------------------------------------------------
module tnd_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire tnd_pkg::tnd_req_t req,
    input  wire logic              done,
    input  wire tnd_pkg::tnd_res_t result
);
    import tnd_pkg::*;

    // every result beat comes from a request the unit took earlier
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 7))
    else $error("result beat without a matching request");

    // an error status carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != STATUS_OK)) |-> (result.value == '0))
    else $error("error status with nonzero value");

    // only deadline requests can fail
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(req.kind != KIND_DEADLINE, 7)) |-> (result.status == STATUS_OK))
    else $error("time read returned an error status");

    // status code stays within the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.status == STATUS_OK) || (result.status == STATUS_NOT_INIT)
                  || (result.status == STATUS_PASSED)))
    else $error("undefined status code");

endmodule

bind tick_to_ns_deadline_unit tnd_checker u_tnd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
);
`default_nettype wire

/* sim/tick_to_ns_deadline_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_to_ns_deadline_unit_tb
// Drives time reads and deadline requests into the conversion unit under
// several register settings and sender idle rates. Each result beat is
// compared with a local prediction of the fixed point conversion.
// ----------------------------------------------------------------------------
module tick_to_ns_deadline_unit_tb;

    import tnd_pkg::*;

    // request kind the unit does not act on
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 200;

    logic        clk;
    logic        rst_n;
    logic        start = 1'b0;
    logic        busy;
    tnd_req_t    req = '0;
    logic        done;
    tnd_res_t    result;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    // register shadow used for prediction
    logic [63:0] ns_per_tick;
    logic [63:0] ticks_per_ns;
    logic [63:0] boot_ns;
    logic        time_ok;

    tnd_req_t pending_reqs[$];
    tnd_res_t expected_results[$];
    int       idle_pct = 0;
    int       mismatches = 0;

    tick_to_ns_deadline_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // bits 32..95 of the full 128 bit product
    function automatic logic [63:0] fixmul_hi(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[95:32];
    endfunction

    // expected result beat for one request beat
    function automatic tnd_res_t predict_conversion(input tnd_req_t r);
        tnd_res_t    res;
        logic [63:0] now_ns;
        logic [63:0] delta;
        now_ns     = fixmul_hi(r.ticks_now, ns_per_tick);
        res.value  = '0;
        res.status = STATUS_OK;
        case (r.kind)
            KIND_MONO: res.value = now_ns;
            KIND_REAL: res.value = boot_ns + now_ns;
            KIND_DEADLINE:
            begin
                delta = r.target_ns - now_ns;
                if (!time_ok)
                    res.status = STATUS_NOT_INIT;
                else if (delta == 64'd0 || delta[63])
                    res.status = STATUS_PASSED;
                else
                    res.value = r.ticks_now + fixmul_hi(delta, ticks_per_ns);
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // tick samples: tiny, near wrap, realistic uptime, anything
    function automatic logic [63:0] rand_ticks();
        case ($urandom_range(7))
            0: return 64'($urandom_range(1000));
            1: return ~64'($urandom_range(1000));
            2, 3: return {24'd0, 8'($urandom), $urandom};
            default: return rand64();
        endcase
    endfunction

    // one register write, shadow follows at once since the unit is idle
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_NS_PER_TICK:  ns_per_tick = data;
            REG_TICKS_PER_NS: ticks_per_ns = data;
            REG_BOOT_OFFSET:  boot_ns = data;
            REG_TIME_VALID:   time_ok = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [63:0] ns_mult, input logic [63:0] tick_mult,
                              input logic [63:0] boot, input logic [63:0] valid_word);
        write_reg(REG_NS_PER_TICK, ns_mult);
        write_reg(REG_TICKS_PER_NS, tick_mult);
        write_reg(REG_BOOT_OFFSET, boot);
        write_reg(REG_TIME_VALID, valid_word);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // multipliers as software would load them for a given counter rate
    task automatic set_rate(input logic [63:0] freq, input logic [63:0] boot,
                            input logic [63:0] valid_word);
        set_config(((64'd1_000_000_000 << 32) + freq - 64'd1) / freq,
                   ((freq << 32) + 64'd999_999_999) / 64'd1_000_000_000,
                   boot, valid_word);
    endtask

    task automatic queue_item(input logic [1:0] kind, input logic [63:0] ticks,
                              input logic [63:0] target);
        tnd_req_t r;
        r.kind      = kind;
        r.ticks_now = ticks;
        r.target_ns = target;
        pending_reqs.push_back(r);
    endtask

    // deadline around now, with the given offset in ns
    task automatic queue_deadline(input logic [63:0] ticks, input logic [63:0] offset);
        queue_item(KIND_DEADLINE, ticks, fixmul_hi(ticks, ns_per_tick) + offset);
    endtask

    // deadlines for about half the items, half of them a little ahead of now, plus edges and noise
    task automatic queue_random_items(input int count);
        tnd_req_t    r;
        logic [63:0] delta;
        int          pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
                r.kind = KIND_MONO;
            else if (pick < 45)
                r.kind = KIND_REAL;
            else if (pick < 93)
                r.kind = KIND_DEADLINE;
            else
                r.kind = KIND_UNUSED;
            r.ticks_now = rand_ticks();
            r.target_ns = rand64();
            if (r.kind == KIND_DEADLINE)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: delta = {24'd0, 8'($urandom), $urandom} + 64'd1;
                    5: delta = 64'($urandom_range(3));
                    6: delta = 64'd0 - {32'd0, $urandom};
                    7: delta = 64'h8000_0000_0000_0000 - 64'($urandom_range(2));
                    default: delta = rand64();
                endcase
                r.target_ns = fixmul_hi(r.ticks_now, ns_per_tick) + delta;
            end
            pending_reqs.push_back(r);
        end
    endtask

    // wait until every beat is sent and answered, then let the pipe settle
    task automatic drain();
        while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
                void'(pending_reqs.pop_front());
            if (!(start && busy))
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    start <= 1'b1;
                    req   <= pending_reqs[0];
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // result monitor and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_results.push_back(predict_conversion(req));
            if (done === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result beat value %h status %0d",
                                 $realtime, result.value, result.status);
                end
                else if (result.value !== expected_results[0].value ||
                         result.status !== expected_results[0].status)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: expected value %h status %0d, got value %h status %0d",
                                 $realtime, expected_results[0].value,
                                 expected_results[0].status, result.value, result.status);
                    void'(expected_results.pop_front());
                end
                else
                    void'(expected_results.pop_front());
            end
        end
    end

    // stimulus sequence
    initial
    begin
        logic [63:0] t;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_NS_PER_TICK;
        cfg_data     = '0;
        ns_per_tick  = '0;
        ticks_per_ns = '0;
        boot_ns      = '0;
        time_ok      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: reads give zero, deadlines not initialized
        queue_item(KIND_MONO, '1, '1);
        queue_item(KIND_REAL, rand64(), rand64());
        queue_item(KIND_DEADLINE, rand64(), '1);
        queue_item(KIND_UNUSED, '1, '1);
        drain();

        // full scale multipliers, valid write with bit 0 clear
        set_config('1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE);
        queue_item(KIND_MONO, '1, '0);
        queue_item(KIND_REAL, '1, '0);
        queue_deadline('1, 64'd1000);
        drain();

        // a 24 MHz counter with the realtime sum wrapping
        set_rate(64'd24_000_000, 64'hFFFF_FFFF_0000_0000, 64'd1);
        t = 64'h0000_00C3_1234_5678;
        queue_deadline(t, 64'd1);
        queue_deadline(t, 64'd0);
        queue_deadline(t, '1);
        queue_deadline(t, 64'h7FFF_FFFF_FFFF_FFFF);
        queue_deadline(t, 64'h8000_0000_0000_0000);
        queue_item(KIND_REAL, '1, '0);
        queue_item(KIND_MONO, '0, '1);
        queue_item(KIND_UNUSED, rand64(), rand64());
        queue_deadline('1, 64'd1_000_000_000);
        drain();

        // random phases, each under its own register setting, with idle rates of 0, 21 and 48 percent
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                2: set_config('1, '1, '0, 64'd1);
                3: set_config('0, '0, '1, 64'd1);
                4: set_config(rand64(), rand64(), rand64(), rand64());
                5: set_rate(64'($urandom_range(32_768, 3_000_000_000)), rand64(),
                            rand64() & ~64'd1);
                7: set_config(64'($urandom_range(16)), 64'($urandom_range(16)), rand64(),
                              rand64() | 64'd1);
                default: set_rate(64'($urandom_range(32_768, 3_000_000_000)), rand64(),
                                  64'd1);
            endcase
            case (phase % 4)
                1: idle_pct = 48;
                3: idle_pct = 21;
                default: idle_pct = 0;
            endcase
            queue_random_items(PHASE_ITEMS);
            drain();
        end

        mismatches += expected_results.size();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
